[design/usm_pkg.sv]
package usm_pkg;

    localparam int RX_DEPTH = 16;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int RX_IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_DEPTH);

    localparam logic [7:0] TC_DELAY_RESET = 8'd20;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_RD_DR = 3'd1,
        FUNC_WR_DR = 3'd2,
        FUNC_RD_SR = 3'd3,
        FUNC_PUSH  = 3'd4
    } func_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_data;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_done;
        logic       push_dropped;
    } result_t;

endpackage

[design/usm_core.sv]
module usm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  usm_pkg::item_t   item,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    output usm_pkg::result_t result
);

    logic [7:0]                  tc_delay_reg;
    logic [7:0]                  shift_reg,       shift_next;
    logic                        receiving_reg,   receiving_next;
    logic                        sending_reg,     sending_next;
    logic                        full_reg,        full_next;
    logic                        busy_reg,        busy_next;
    logic                        clr_pend_reg,    clr_pend_next;
    logic [7:0]                  tc_cnt_reg,      tc_cnt_next;
    logic                        tc_armed_reg,    tc_armed_next;
    logic [7:0]                  data_reg,        data_next;
    logic                        ore_reg,         ore_next;
    logic                        rxne_reg,        rxne_next;
    logic                        tc_reg,          tc_next;
    logic                        txe_reg,         txe_next;
    logic [usm_pkg::RX_CNT_W-1:0] rx_pos_reg,     rx_pos_next;
    logic [usm_pkg::RX_CNT_W-1:0] rx_len_reg,     rx_len_next;
    logic [7:0]                  rx_store [usm_pkg::RX_DEPTH];
    logic                        push_en;
    logic [7:0]                  store_rd;

    assign store_rd = rx_store[rx_pos_reg[usm_pkg::RX_IDX_W-1:0]];
    assign push_en  = step_en && (usm_pkg::func_t'(item.func) == usm_pkg::FUNC_PUSH)
                   && (rx_len_reg < usm_pkg::RX_FULL);

    always_comb
    begin
        shift_next     = shift_reg;
        receiving_next = receiving_reg;
        sending_next   = sending_reg;
        full_next      = full_reg;
        busy_next      = busy_reg;
        clr_pend_next  = clr_pend_reg;
        tc_cnt_next    = tc_cnt_reg;
        tc_armed_next  = tc_armed_reg;
        data_next      = data_reg;
        ore_next       = ore_reg;
        rxne_next      = rxne_reg;
        tc_next        = tc_reg;
        txe_next       = txe_reg;
        rx_pos_next    = rx_pos_reg;
        rx_len_next    = rx_len_reg;
        result         = '0;

        unique case (usm_pkg::func_t'(item.func))
            usm_pkg::FUNC_TICK:
            begin
                // receiver runs only while the shifter is not owned by a send
                if (!busy_reg)
                begin
                    if (receiving_reg)
                    begin
                        if (rx_len_reg == '0)
                        begin
                            receiving_next = 1'b0;
                        end
                        else if (rx_pos_reg >= rx_len_reg || rx_pos_reg >= usm_pkg::RX_FULL)
                        begin
                            // store drained: rewind it
                            receiving_next = 1'b0;
                            rx_len_next    = '0;
                            rx_pos_next    = '0;
                        end
                        else
                        begin
                            shift_next     = store_rd;
                            full_next      = 1'b1;
                            receiving_next = 1'b0;
                        end
                    end
                    else if (full_reg)
                    begin
                        if (rxne_reg)
                        begin
                            ore_next = 1'b1;
                        end
                        else
                        begin
                            data_next      = shift_reg;
                            rxne_next      = 1'b1;
                            full_next      = 1'b0;
                            receiving_next = 1'b1;
                            if (rx_pos_reg < usm_pkg::RX_FULL)
                                rx_pos_next = rx_pos_reg + 1'b1;
                        end
                    end
                    else if (rx_len_reg != '0)
                    begin
                        receiving_next = 1'b1;
                    end
                end
                else
                begin
                    if (tc_armed_reg && tc_cnt_reg != 8'd0)
                        tc_cnt_next = tc_cnt_reg - 8'd1;
                    priority if (sending_reg)
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = shift_reg;
                        full_next       = 1'b0;
                        sending_next    = 1'b0;
                        tc_cnt_next     = tc_delay_reg;
                        tc_armed_next   = 1'b1;
                    end
                    else if (full_reg)
                    begin
                        sending_next = 1'b1;
                    end
                    else if (!txe_reg)
                    begin
                        shift_next = data_reg;
                        full_next  = 1'b1;
                        txe_next   = 1'b1;
                    end
                    else if (tc_armed_reg && tc_cnt_next == 8'd0)
                    begin
                        busy_next      = 1'b0;
                        tc_armed_next  = 1'b0;
                        tc_next        = 1'b1;
                        result.tx_done = 1'b1;
                    end
                end
            end
            usm_pkg::FUNC_RD_DR:
            begin
                result.read_value = data_reg;
                rxne_next = 1'b0;
                // the shifter content moves in once RXNE has dropped
                if (full_reg)
                begin
                    data_next      = shift_reg;
                    rxne_next      = 1'b1;
                    full_next      = 1'b0;
                    receiving_next = 1'b1;
                    if (rx_pos_reg < usm_pkg::RX_FULL)
                        rx_pos_next = rx_pos_reg + 1'b1;
                end
                if (clr_pend_reg)
                begin
                    clr_pend_next = 1'b0;
                    ore_next      = 1'b0;
                end
            end
            usm_pkg::FUNC_WR_DR:
            begin
                data_next     = item.tx_data;
                txe_next      = 1'b0;
                tc_next       = 1'b0;
                busy_next     = 1'b1;
                tc_armed_next = 1'b0;
                tc_cnt_next   = 8'd0;
            end
            usm_pkg::FUNC_RD_SR:
            begin
                result.read_value = {txe_reg, tc_reg, rxne_reg, 1'b0, ore_reg, 3'b000};
                if (ore_reg)
                    clr_pend_next = 1'b1;
            end
            usm_pkg::FUNC_PUSH:
            begin
                if (rx_len_reg < usm_pkg::RX_FULL)
                    rx_len_next = rx_len_reg + 1'b1;
                else
                    result.push_dropped = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_delay_reg  <= usm_pkg::TC_DELAY_RESET;
            shift_reg     <= 8'd0;
            receiving_reg <= 1'b0;
            sending_reg   <= 1'b0;
            full_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            clr_pend_reg  <= 1'b0;
            tc_cnt_reg    <= 8'd0;
            tc_armed_reg  <= 1'b0;
            data_reg      <= 8'd0;
            ore_reg       <= 1'b0;
            rxne_reg      <= 1'b0;
            tc_reg        <= 1'b1;
            txe_reg       <= 1'b1;
            rx_pos_reg    <= '0;
            rx_len_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                tc_delay_reg <= cfg_wdata;
            if (step_en)
            begin
                shift_reg     <= shift_next;
                receiving_reg <= receiving_next;
                sending_reg   <= sending_next;
                full_reg      <= full_next;
                busy_reg      <= busy_next;
                clr_pend_reg  <= clr_pend_next;
                tc_cnt_reg    <= tc_cnt_next;
                tc_armed_reg  <= tc_armed_next;
                data_reg      <= data_next;
                ore_reg       <= ore_next;
                rxne_reg      <= rxne_next;
                tc_reg        <= tc_next;
                txe_reg       <= txe_next;
                rx_pos_reg    <= rx_pos_next;
                rx_len_reg    <= rx_len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            rx_store[rx_len_reg[usm_pkg::RX_IDX_W-1:0]] <= item.rx_byte;
    end

    a_armed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tc_armed_reg |-> busy_reg)
        else $error("tc wait armed without an active send");

    a_tc_txe: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg |-> txe_reg)
        else $error("TC set while data register still holds an unsent byte");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_pos_reg <= usm_pkg::RX_FULL) && (rx_len_reg <= usm_pkg::RX_FULL))
        else $error("receive position or length beyond store depth");

    a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |=> rx_len_reg == $past(rx_len_reg) + 1'b1)
        else $error("accepted push did not advance the store length");

endmodule

[design/uart_status_and_shift_model.sv]
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    func, tx_data, rx_byte
// out       source     out_valid / out_stall  read_value, tx_valid, tx_byte, tx_done,
//                                             push_dropped
// cfg       sink       cfg_we                 cfg_wdata (tc_delay)
//
// One item is taken per cycle while in_stall is low; its result is registered into the output register.
// The whole step is one combinational pass from the state registers to the result register.
// in_stall follows out_stall while the output register holds a result not yet taken.
// Reset is asynchronous and takes effect at once; no clearing pass follows it.
module uart_status_and_shift_model (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [7:0] tx_data,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_value,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       tx_done,
    output logic       push_dropped,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    usm_pkg::item_t   item;
    usm_pkg::result_t step_result;
    usm_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             step_en;

    assign item     = '{func: func, tx_data: tx_data, rx_byte: rx_byte};
    // hold the input while a finished result waits downstream
    assign in_stall = out_valid_reg && out_stall;
    assign step_en  = in_valid && !in_stall;

    usm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = result_reg.read_value;
    assign tx_valid     = result_reg.tx_valid;
    assign tx_byte      = result_reg.tx_byte;
    assign tx_done      = result_reg.tx_done;
    assign push_dropped = result_reg.push_dropped;

endmodule
